[sv/bpq_pkg.sv]
// Shared types and constants for the bounded priority queue.
package bpq_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // How the datapath closes out a request.
  typedef enum logic [1:0] {
    RES_STATUS  = 2'd0,
    RES_ADDED   = 2'd1,
    RES_TAKEN   = 2'd2,
    RES_CLEARED = 2'd3
  } res_e;

  typedef struct packed {
    logic write_tail;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic finish;
    res_e kind;
  } bpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic sweep_done;
  } bpq_stat_t;

endpackage

[sv/bpq_ctrl.sv]
// Request sequencer for the bounded priority queue.
module bpq_ctrl
  import bpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [OP_W-1:0]     operation_i,
  input  bpq_stat_t           stat_i,
  output bpq_cmd_t            cmd_o,
  output logic                busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  assign op   = op_e'(operation_i);
  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{write_tail: 1'b0, scan_start: 1'b0, scan_step: 1'b0,
                shift_start: 1'b0, shift_step: 1'b0, finish: 1'b0,
                kind: RES_STATUS};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_ADD: begin
              cmd_o.write_tail = !stat_i.full;
              cmd_o.finish     = 1'b1;
              if (!stat_i.full) begin
                cmd_o.kind = RES_ADDED;
              end
            end
            OP_EXTRACT: begin
              if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              cmd_o.finish = 1'b1;
              cmd_o.kind   = RES_CLEARED;
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.sweep_done) begin
          cmd_o.shift_start = 1'b1;
          state_d           = ST_SHIFT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (stat_i.sweep_done) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RES_TAKEN;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/bpq_datapath.sv]
// Entry storage, scan and shift datapath, and result registers of the queue.
module bpq_datapath
  import bpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpq_cmd_t             cmd_i,
  input  logic [VAL_W-1:0]     job_value_i,
  input  logic [PRI_W-1:0]     priority_req_i,
  output bpq_stat_t            stat_o,
  output logic                 done_o,
  output logic [VAL_W-1:0]     out_value_o,
  output logic                 out_valid_o,
  output logic                 accepted_o,
  output logic [CNT_OUT_W-1:0] count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [PRI_W-1:0] pri_mem [DEPTH];

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    tag_q, tag_d;
  logic             pend_q;
  logic [VAL_W-1:0] rval_q;
  logic [PRI_W-1:0] rpri_q;
  logic [CW-1:0]    best_pos_q;
  logic [PRI_W-1:0] best_pri_q;
  logic [VAL_W-1:0] best_val_q;

  logic             issue;
  logic             take;
  logic             we;
  logic [CW-1:0]    tag_m1;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wval;
  logic [PRI_W-1:0] wpri;

  logic                 done_q;
  logic [VAL_W-1:0]     out_value_q;
  logic                 out_valid_q;
  logic                 accepted_q;
  logic [CNT_OUT_W-1:0] count_q;
  logic                 empty_q;
  logic                 full_q;

  assign stat_o.full       = (cnt_q == CW'(DEPTH));
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.sweep_done = (idx_q >= cnt_q) && !pend_q;

  // Issue one read per cycle during a scan or shift step while the sweep index is below the count.
  assign issue = (cmd_i.scan_step || cmd_i.shift_step) && (idx_q < cnt_q);
  // Replace the best only on a strictly larger priority: the oldest wins ties.
  assign take  = cmd_i.scan_step && pend_q && ((tag_q == '0) || (rpri_q > best_pri_q));

  assign tag_m1 = tag_q - CW'(1);
  assign we     = cmd_i.write_tail || (cmd_i.shift_step && pend_q);
  assign waddr  = cmd_i.write_tail ? cnt_q[AW-1:0] : tag_m1[AW-1:0];
  assign wval   = cmd_i.write_tail ? job_value_i : rval_q;
  assign wpri   = cmd_i.write_tail ? priority_req_i : rpri_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_start) begin
      idx_d = '0;
    end else if (cmd_i.shift_start) begin
      idx_d = best_pos_q + CW'(1);
    end else if (issue) begin
      idx_d = idx_q + CW'(1);
    end
    tag_d = issue ? idx_q : tag_q;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish) begin
      case (cmd_i.kind)
        RES_ADDED:   cnt_d = cnt_q + CW'(1);
        RES_TAKEN:   cnt_d = cnt_q - CW'(1);
        RES_CLEARED: cnt_d = '0;
        default:     cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      val_mem[waddr] <= wval;
      pri_mem[waddr] <= wpri;
    end
    rval_q <= val_mem[idx_q[AW-1:0]];
    rpri_q <= pri_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_pos_q <= tag_q;
      best_pri_q <= rpri_q;
      best_val_q <= rval_q;
    end
    tag_q <= tag_d;
    if (cmd_i.finish) begin
      out_valid_q <= (cmd_i.kind == RES_TAKEN);
      out_value_q <= (cmd_i.kind == RES_TAKEN) ? best_val_q : '0;
      accepted_q  <= (cmd_i.kind == RES_ADDED);
      count_q     <= CNT_OUT_W'(cnt_d);
      empty_q     <= (cnt_d == '0);
      full_q      <= (cnt_d == CW'(DEPTH));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      pend_q <= issue;
      done_q <= cmd_i.finish;
    end
  end

  assign done_o      = done_q;
  assign out_value_o = out_value_q;
  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign count_o     = count_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && accepted_q) |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("stored add did not grow the count by one");

  a_take_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_valid_q) |-> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("extract did not shrink the count by one");

  a_shift_write_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_step && pend_q) |-> (tag_q != '0) && (tag_q < cnt_q))
    else $error("shift write outside the occupied range");

endmodule

[sv/bounded_priority_queue.sv]
// Top level of the bounded priority queue: sequencer plus datapath.
//
// Usage: drive operation_i (add, extract, clear, no-op), job_value_i and
// priority_req_i and raise start; the request is taken at the rising edge
// where start is high and busy is low. Exactly one result follows per
// request, shown for a single cycle with done_o high: out_value_o and
// out_valid_o for an extract, accepted_o for an add, and count_o,
// is_empty_o, is_full_o as they stand after the request.
// Add, clear, no-op and extract on an empty queue strobe done_o in the cycle
// after the request is taken. An extract on N entries whose winner sits at
// position p scans all N entries and then moves the N-p-1 later entries
// down one place. Both sweeps go one entry per cycle through the single
// read port of the entry memory, which sets how long an extract takes.
// busy stays high for the whole extract on a non-empty queue; a new request
// may be taken in the same cycle that the previous result is on the ports.
// Reset empties the queue; entry contents are not cleared and need not be.
// The receiver cannot stall: a result not taken in its cycle is gone.
module bounded_priority_queue
  import bpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [VAL_W-1:0]     job_value_i,
  input  logic [PRI_W-1:0]     priority_req_i,
  output logic                 done_o,
  output logic [VAL_W-1:0]     out_value_o,
  output logic                 out_valid_o,
  output logic                 accepted_o,
  output logic [CNT_OUT_W-1:0] count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);

  bpq_cmd_t  cmd;
  bpq_stat_t stat;

  // Sequence each request: decode, scan for the best entry, close the gap.
  bpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // Hold entries, run the sweeps, and register the result.
  bpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .job_value_i    (job_value_i),
    .priority_req_i (priority_req_i),
    .stat_o         (stat),
    .done_o         (done_o),
    .out_value_o    (out_value_o),
    .out_valid_o    (out_valid_o),
    .accepted_o     (accepted_o),
    .count_o        (count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule

[verif/tb_bounded_priority_queue.sv]
// Self-checking testbench for the bounded priority queue: directed and random requests.
`timescale 1ns / 100ps

module tb_bounded_priority_queue;
  import bpq_pkg::*;

  localparam int unsigned QDEPTH     = 16;
  localparam int unsigned N_RANDOM   = 1250;
  localparam int unsigned MAX_CYCLES = 500_000;
  localparam int unsigned MAX_REPORT = 60;
  // Wait long enough to cover the longest extract, with margin on top.
  localparam int unsigned TAIL_WAIT  = 2 * QDEPTH + 8;

  // One request as the driver presents it, plus the idle time before it and
  // whether the sender must first see every earlier result.
  typedef struct {
    op_e               op;
    logic [VAL_W-1:0]  value;
    logic [PRI_W-1:0]  prio;
    int unsigned       gap;
    bit                drain;
  } request_t;

  // What the block reports for one request.
  typedef struct {
    logic [VAL_W-1:0]     value;
    logic                 valid;
    logic                 accepted;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty;
    logic                 full;
  } result_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic [OP_W-1:0]      operation_i    = OP_NOP;
  logic [VAL_W-1:0]     job_value_i    = '0;
  logic [PRI_W-1:0]     priority_req_i = '0;
  logic                 busy;
  logic                 done_o;
  logic [VAL_W-1:0]     out_value_o;
  logic                 out_valid_o;
  logic                 accepted_o;
  logic [CNT_OUT_W-1:0] count_o;
  logic                 is_empty_o;
  logic                 is_full_o;

  bounded_priority_queue #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .job_value_i   (job_value_i),
    .priority_req_i(priority_req_i),
    .done_o        (done_o),
    .out_value_o   (out_value_o),
    .out_valid_o   (out_valid_o),
    .accepted_o    (accepted_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue contents, kept in arrival order.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] held_value [QDEPTH];
  logic [PRI_W-1:0] held_prio  [QDEPTH];
  int               held_count = 0;

  // Tallies for the closing summary.
  int n_add = 0, n_dropped = 0, n_extract = 0, n_extract_empty = 0;
  int n_clear = 0, n_nop = 0, n_tie_wins = 0, n_full_seen = 0;

  request_t pending_requests[$];
  result_t  expected_results [0:4095];
  int       requests_taken  = 0;  // written by the driver only
  int       results_checked = 0;  // written by the monitor only
  int       err_cnt         = 0;
  int       cycle_cnt       = 0;
  int unsigned idle_left    = 0;
  int       gen_count       = 0;  // entry count as the stimulus generator sees it

  // Apply one request to the shadow queue and return what the block must report.
  function automatic result_t serve_request(op_e op, logic [VAL_W-1:0] value,
                                            logic [PRI_W-1:0] prio);
    result_t r;
    int      best;
    bit      tie;
    r    = '{default: '0};
    best = 0;
    tie  = 1'b0;
    case (op)
      OP_ADD: begin
        n_add++;
        if (held_count < QDEPTH) begin
          held_value[held_count] = value;
          held_prio[held_count]  = prio;
          held_count++;
          r.accepted = 1'b1;
        end else begin
          n_dropped++;
        end
      end
      OP_EXTRACT: begin
        n_extract++;
        if (held_count > 0) begin
          // Strictly greater only: the oldest entry keeps a tie.
          for (int i = 1; i < held_count; i++) begin
            if (held_prio[i] > held_prio[best]) best = i;
          end
          for (int i = best + 1; i < held_count; i++) begin
            if (held_prio[i] == held_prio[best]) tie = 1'b1;
          end
          if (tie) n_tie_wins++;
          r.value = held_value[best];
          r.valid = 1'b1;
          // Close the gap, keeping the order of the later entries.
          for (int i = best; i < held_count - 1; i++) begin
            held_value[i] = held_value[i + 1];
            held_prio[i]  = held_prio[i + 1];
          end
          held_count--;
        end else begin
          n_extract_empty++;
        end
      end
      OP_CLEAR: begin
        n_clear++;
        held_count = 0;
      end
      default: begin
        n_nop++;
      end
    endcase
    r.count = CNT_OUT_W'(held_count);
    r.empty = (held_count == 0);
    r.full  = (held_count == QDEPTH);
    if (r.full) n_full_seen++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, now and then a long pause.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Narrow ranges make equal priorities common; keep the extremes in play.
  function automatic logic [PRI_W-1:0] pick_prio(bit narrow);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (narrow) return PRI_W'($urandom_range(0, 3));
    return PRI_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  // Queue one request and track the entry count it leaves behind.
  task automatic push_request(op_e op, logic [VAL_W-1:0] value, logic [PRI_W-1:0] prio,
                              int unsigned gap, bit drain);
    request_t req;
    req = '{op: op, value: value, prio: prio, gap: gap, drain: drain};
    pending_requests.push_back(req);
    case (op)
      OP_ADD:     if (gen_count < QDEPTH) gen_count++;
      OP_EXTRACT: if (gen_count > 0) gen_count--;
      OP_CLEAR:   gen_count = 0;
      default:    ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present requests from pending_requests, honoring gaps and drains.
  // Inputs and start change only at the rising edge or on reset, each once per step.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    request_t req;
    bit       took;
    int       outstanding;
    if (!rst_ni) begin
      start          <= 1'b0;
      operation_i    <= OP_NOP;
      job_value_i    <= '0;
      priority_req_i <= '0;
      idle_left      <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        // Predict now, on the exact fields the block just took.
        expected_results[requests_taken] =
          serve_request(op_e'(operation_i), job_value_i, priority_req_i);
        requests_taken <= requests_taken + 1;
      end
      outstanding = requests_taken + int'(took) - results_checked;
      if (start && !took) begin
        // Hold the request until the block is free.
      end else if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && outstanding != 0)) begin
        req = pending_requests.pop_front();
        operation_i    <= req.op;
        job_value_i    <= req.value;
        priority_req_i <= req.prio;
        start          <= 1'b1;
        if (pending_requests.size() != 0) idle_left <= pending_requests[0].gap;
      end else begin
        // Nothing to send, or hold off until all earlier results are back.
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done_o pulse is one result; compare with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORT)
        $error("request %0d: %s expected 0x%0h, got 0x%0h",
               results_checked, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t exp_res;
    if (rst_ni && done_o) begin
      if (results_checked >= requests_taken) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORT) $error("result strobe with no request outstanding");
      end else begin
        exp_res = expected_results[results_checked];
        check_field("out_value", exp_res.value,    out_value_o);
        check_field("out_valid", exp_res.valid,    out_valid_o);
        check_field("accepted",  exp_res.accepted, accepted_o);
        check_field("count",     exp_res.count,    count_o);
        check_field("is_empty",  exp_res.empty,    is_empty_o);
        check_field("is_full",   exp_res.full,     is_full_o);
        results_checked <= results_checked + 1;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned roll;
    bit          quiet;
    bit          narrow;
    op_e         op;

    // Directed part: empty-queue cases, extremes, ties, full queue.
    push_request(OP_EXTRACT, '1, '1, 0, 1'b0);      // extract on empty
    push_request(OP_NOP, 16'h1234, 8'h55, 0, 1'b0);  // unused code, no change
    push_request(OP_CLEAR, '0, '0, 2, 1'b0);         // clear on empty
    push_request(OP_ADD, 16'h0000, 8'h00, 0, 1'b0);
    push_request(OP_ADD, 16'hFFFF, 8'hFF, 0, 1'b0);
    push_request(OP_ADD, 16'h5555, 8'hFF, 1, 1'b0);  // same priority, younger
    push_request(OP_ADD, 16'hAAAA, 8'h80, 0, 1'b0);
    push_request(OP_EXTRACT, '0, '0, 0, 1'b0);       // oldest of the 0xFF pair
    push_request(OP_EXTRACT, '0, '0, 3, 1'b0);       // then the younger one
    push_request(OP_NOP, '0, '0, 0, 1'b1);           // wait for all results first
    for (int i = 0; i < QDEPTH - 2; i++)
      push_request(OP_ADD, VAL_W'(16'h1000 + i), PRI_W'(i % 3), i % 2, 1'b0);
    push_request(OP_ADD, 16'hFFFF, 8'hFF, 0, 1'b0);  // add when full: dropped
    push_request(OP_EXTRACT, '0, '0, 0, 1'b0);
    push_request(OP_CLEAR, '0, '0, 0, 1'b1);
    push_request(OP_EXTRACT, '0, '0, 0, 1'b0);

    // Random part: fill and drain runs with random content, plus noise.
    while (pending_requests.size() < N_RANDOM + 28) begin
      kind   = $urandom_range(0, 99);
      quiet  = ($urandom_range(0, 4) == 0);  // a run with no idling at all
      narrow = ($urandom_range(0, 1) == 0);
      if (kind < 40) begin
        len = $urandom_range(1, QDEPTH - gen_count + 2);
        repeat (len) push_request(OP_ADD, pick_value(), pick_prio(narrow),
                                  pick_gap(quiet), 1'b0);
      end else if (kind < 75) begin
        len = $urandom_range(1, gen_count + 1);
        repeat (len) push_request(OP_EXTRACT, pick_value(), pick_prio(narrow),
                                  pick_gap(quiet), 1'b0);
      end else if (kind < 92) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          roll = $urandom_range(0, 19);
          if (roll < 8)       op = OP_ADD;
          else if (roll < 16) op = OP_EXTRACT;
          else if (roll < 17) op = OP_CLEAR;
          else                op = OP_NOP;
          push_request(op, pick_value(), pick_prio(narrow), pick_gap(quiet), 1'b0);
        end
      end else if (kind < 96) begin
        push_request(OP_CLEAR, pick_value(), pick_prio(narrow), pick_gap(quiet), 1'b0);
      end else begin
        // Pause the sender until the block has answered everything.
        push_request(OP_EXTRACT, pick_value(), pick_prio(narrow), pick_gap(quiet), 1'b1);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample mid-cycle so that the driver's and monitor's updates have settled.
    while (pending_requests.size() != 0 || start || results_checked != requests_taken)
      @(negedge clk_i);
    // Give a stray late strobe the chance to show up.
    repeat (TAIL_WAIT) @(negedge clk_i);
    if (results_checked != requests_taken) begin
      err_cnt++;
      $error("%0d predicted results never arrived", requests_taken - results_checked);
    end

    $display("Run covered %0d requests: %0d adds (%0d refused while full), %0d extracts",
             requests_taken, n_add, n_dropped, n_extract);
    $display("(%0d on empty, %0d tie wins), %0d clears, %0d no-ops, %0d full results seen",
             n_extract_empty, n_tie_wins, n_clear, n_nop, n_full_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
